// ===== design/ipdal_pkg.sv =====
package ipdal_pkg;

    localparam int CFG_DATA_W = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int BOOST_W    = 10;
    localparam int IN_W       = 18;
    localparam int OUT_W      = 17;

    // register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_KP_GAIN         = 3'd0,
        REG_KD_GAIN         = 3'd1,
        REG_JUMP_LIMIT      = 3'd2,
        REG_BOOST_THRESHOLD = 3'd3,
        REG_BOOST_FACTOR    = 3'd4,
        REG_DEADBAND        = 3'd5,
        REG_OUTPUT_LIMIT    = 3'd6
    } reg_idx_t;

    localparam logic [15:0]        RST_KP_GAIN         = 16'd3932;
    localparam logic [15:0]        RST_KD_GAIN         = 16'd131;
    localparam logic [15:0]        RST_JUMP_LIMIT      = 16'd2560;
    localparam logic [15:0]        RST_BOOST_THRESHOLD = 16'd512;
    localparam logic [BOOST_W-1:0] RST_BOOST_FACTOR    = 10'd333;
    localparam logic [15:0]        RST_DEADBAND        = 16'd51;
    localparam logic [15:0]        RST_OUTPUT_LIMIT    = 16'd21760;

    // unity in Q2.8
    localparam logic [BOOST_W-1:0] BOOST_ONE = 10'd256;

    typedef struct packed {
        logic [15:0]        kp_gain;
        logic [15:0]        kd_gain;
        logic [15:0]        jump_limit;
        logic [15:0]        boost_threshold;
        logic [BOOST_W-1:0] boost_factor;
        logic [15:0]        deadband;
        logic [15:0]        output_limit;
    } cfg_t;

    typedef enum logic [2:0] {
        ALU_NOP,
        ALU_LOAD,
        ALU_SELECT,
        ALU_WRAP,
        ALU_CLASS,
        ALU_ACC_D,
        ALU_ACC_P,
        ALU_SAT
    } alu_op_t;

    typedef enum logic [1:0] {
        MUL_NONE,
        MUL_KD_BOOST,
        MUL_KB_DIFF,
        MUL_KP_ERR
    } mul_sel_t;

    typedef struct packed {
        alu_op_t  alu;
        mul_sel_t mul;
    } ctrl_t;

endpackage

// ===== design/incremental_pd_angle_loop_top.sv =====
// Incremental PD angle loop.
// Input channel: in_valid / in_ready carry one measured_angle request (signed,
// 1/2^ANGLE_FRAC_BITS degree). Output channel: out_valid / out_ready carry
// drive_angle and filtered_error, one result per request.
// Configuration: write cfg_data to register cfg_index when cfg_we is high;
// indexes 0..6 are kp_gain, kd_gain, jump_limit, boost_threshold,
// boost_factor, deadband, output_limit. Write only while idle.
// Timing: a microcoded sequencer steps through a nine-word program around a
// single shared 28 x (F+10) multiplier, one word per cycle except where it
// holds for a request or for the output register. A new request is taken only
// after the last step of the program for the previous one has run.
// The result sits in an output register, so the next request is taken while
// it waits; if the receiver is still stalling when the next result is due,
// the sequencer holds on its last step until out_ready.
// Reset clears the error history and the drive accumulator and loads the
// registers with their defaults; in_ready is high straight after reset.
module incremental_pd_angle_loop_top
#(
    parameter int ANGLE_FRAC_BITS = 8
)
(
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_we,
    input  logic [ipdal_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [ipdal_pkg::CFG_DATA_W-1:0]      cfg_data,
    input  logic                                  in_valid,
    output logic                                  in_ready,
    input  logic signed [ipdal_pkg::IN_W-1:0]     measured_angle,
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output logic signed [ipdal_pkg::OUT_W-1:0]    drive_angle,
    output logic signed [ipdal_pkg::OUT_W-1:0]    filtered_error
);
    import ipdal_pkg::*;

    cfg_t  cfg;
    ctrl_t ctrl;

    ipdal_cfg u_cfg
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    ipdal_seq u_seq
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .ctrl      (ctrl)
    );

    ipdal_dp
    #(
        .ANGLE_FRAC_BITS (ANGLE_FRAC_BITS)
    )
    u_dp
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .ctrl           (ctrl),
        .cfg            (cfg),
        .measured_angle (measured_angle),
        .drive_angle    (drive_angle),
        .filtered_error (filtered_error)
    );

endmodule

// ===== design/ipdal_cfg.sv =====
module ipdal_cfg
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_we,
    input  logic [ipdal_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [ipdal_pkg::CFG_DATA_W-1:0]   cfg_data,
    output ipdal_pkg::cfg_t                    cfg
);
    import ipdal_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                REG_KP_GAIN:         cfg_next.kp_gain         = cfg_data;
                REG_KD_GAIN:         cfg_next.kd_gain         = cfg_data;
                REG_JUMP_LIMIT:      cfg_next.jump_limit      = cfg_data;
                REG_BOOST_THRESHOLD: cfg_next.boost_threshold = cfg_data;
                REG_BOOST_FACTOR:    cfg_next.boost_factor    = cfg_data[BOOST_W-1:0];
                REG_DEADBAND:        cfg_next.deadband        = cfg_data;
                REG_OUTPUT_LIMIT:    cfg_next.output_limit    = cfg_data;
                default:             cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.kp_gain         <= RST_KP_GAIN;
            cfg_reg.kd_gain         <= RST_KD_GAIN;
            cfg_reg.jump_limit      <= RST_JUMP_LIMIT;
            cfg_reg.boost_threshold <= RST_BOOST_THRESHOLD;
            cfg_reg.boost_factor    <= RST_BOOST_FACTOR;
            cfg_reg.deadband        <= RST_DEADBAND;
            cfg_reg.output_limit    <= RST_OUTPUT_LIMIT;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// ===== design/ipdal_seq.sv =====
module ipdal_seq
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    output logic             out_valid,
    input  logic             out_ready,
    output ipdal_pkg::ctrl_t ctrl
);
    import ipdal_pkg::*;

    localparam int NSTEP  = 9;
    localparam int STEP_W = $clog2(NSTEP);

    typedef enum logic [1:0] {
        COND_NEXT,
        COND_REQ,
        COND_OUT
    } cond_t;

    typedef struct packed {
        alu_op_t           alu;
        mul_sel_t          mul;
        cond_t             cond;
        logic [STEP_W-1:0] target;
    } uword_t;

    function automatic uword_t rom(input logic [STEP_W-1:0] addr);
        uword_t w;
        case (addr)
            STEP_W'(0): w = '{ALU_LOAD,   MUL_NONE,     COND_REQ,  STEP_W'(1)};
            STEP_W'(1): w = '{ALU_SELECT, MUL_NONE,     COND_NEXT, STEP_W'(2)};
            STEP_W'(2): w = '{ALU_WRAP,   MUL_NONE,     COND_NEXT, STEP_W'(3)};
            STEP_W'(3): w = '{ALU_CLASS,  MUL_NONE,     COND_NEXT, STEP_W'(4)};
            STEP_W'(4): w = '{ALU_NOP,    MUL_KD_BOOST, COND_NEXT, STEP_W'(5)};
            STEP_W'(5): w = '{ALU_NOP,    MUL_KB_DIFF,  COND_NEXT, STEP_W'(6)};
            STEP_W'(6): w = '{ALU_ACC_D,  MUL_KP_ERR,   COND_NEXT, STEP_W'(7)};
            STEP_W'(7): w = '{ALU_ACC_P,  MUL_NONE,     COND_NEXT, STEP_W'(8)};
            STEP_W'(8): w = '{ALU_SAT,    MUL_NONE,     COND_OUT,  STEP_W'(0)};
            default:    w = '{ALU_NOP,    MUL_NONE,     COND_NEXT, STEP_W'(0)};
        endcase
        return w;
    endfunction

    logic [STEP_W-1:0] step_reg;
    logic [STEP_W-1:0] step_next;
    logic              out_valid_reg;
    logic              out_valid_next;
    uword_t            word;
    logic              hold;

    assign word = rom(step_reg);

    // wait for a request, or for the output register to free up
    assign hold = ((word.cond == COND_REQ) && !in_valid)
               || ((word.cond == COND_OUT) && out_valid_reg && !out_ready);

    always_comb
    begin
        if (hold)
        begin
            ctrl      = '{ALU_NOP, MUL_NONE};
            step_next = step_reg;
        end
        else
        begin
            ctrl      = '{word.alu, word.mul};
            step_next = word.target;
        end

        if (ctrl.alu == ALU_SAT)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_ready  = (word.cond == COND_REQ);
    assign out_valid = out_valid_reg;

endmodule

// ===== design/ipdal_dp.sv =====
module ipdal_dp
#(
    parameter int ANGLE_FRAC_BITS = 8
)
(
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  ipdal_pkg::ctrl_t                      ctrl,
    input  ipdal_pkg::cfg_t                       cfg,
    input  logic signed [ipdal_pkg::IN_W-1:0]     measured_angle,
    output logic signed [ipdal_pkg::OUT_W-1:0]    drive_angle,
    output logic signed [ipdal_pkg::OUT_W-1:0]    filtered_error
);
    import ipdal_pkg::*;

    localparam int F  = ANGLE_FRAC_BITS;
    localparam int EW = F + 9;                          // wrapped error
    localparam int VW = (F + 11 > IN_W + 1) ? F + 11 : IN_W + 1;
    localparam int DW = F + 10;                         // multiplier B operand
    localparam int PW = DW + 28;                        // product
    localparam int AW = F + 17;                         // accumulator
    localparam int SW = ((F + 17 > 2 * F + 12) ? F + 17 : 2 * F + 12) + 2;

    localparam logic signed [VW-1:0] FULL     = VW'(360) << F;
    localparam logic signed [VW-1:0] HALF     = VW'(180) << F;
    localparam logic signed [VW-1:0] NEG_FULL = -FULL;
    localparam logic signed [VW-1:0] NEG_HALF = -HALF;

    logic signed [VW-1:0]    v_reg, v_next;
    logic signed [VW-1:0]    err_reg, err_next;
    logic signed [EW-1:0]    cur_reg, cur_next;
    logic signed [EW-1:0]    prev_reg, prev_next;
    logic [BOOST_W-1:0]      boost_reg, boost_next;
    logic signed [PW-1:0]    prod_reg, prod_next;
    logic signed [SW-1:0]    sum_reg, sum_next;
    logic signed [AW-1:0]    acc_reg, acc_next;
    logic signed [OUT_W-1:0] drive_reg, drive_next;
    logic signed [OUT_W-1:0] ferr_reg, ferr_next;

    logic signed [VW-1:0]    v_in;
    logic signed [VW-1:0]    diff;
    logic [VW-1:0]           diff_mag;
    logic [VW-1:0]           err_mag;
    logic [26:0]             mul_a;
    logic signed [DW-1:0]    mul_b;
    logic signed [SW-1:0]    lim_pos;
    logic signed [SW-1:0]    lim_neg;
    logic signed [SW-1:0]    sat;

    // shared multiplier, operand A unsigned
    always_comb
    begin
        case (ctrl.mul)
            MUL_KD_BOOST:
            begin
                mul_a = 27'(cfg.kd_gain);
                mul_b = DW'({1'b0, boost_reg});
            end
            MUL_KB_DIFF:
            begin
                mul_a = prod_reg[26:0];
                mul_b = DW'(cur_reg) - DW'(prev_reg);
            end
            MUL_KP_ERR:
            begin
                mul_a = 27'(cfg.kp_gain);
                mul_b = DW'(cur_reg);
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign v_in     = VW'(measured_angle);
    assign diff     = v_reg - VW'(cur_reg);
    assign diff_mag = diff[VW-1] ? VW'(-diff) : VW'(diff);
    assign err_mag  = err_reg[VW-1] ? VW'(-err_reg) : VW'(err_reg);
    assign lim_pos  = SW'({1'b0, cfg.output_limit}) << F;
    assign lim_neg  = -lim_pos;

    always_comb
    begin
        if (sum_reg > lim_pos)
            sat = lim_pos;
        else if (sum_reg < lim_neg)
            sat = lim_neg;
        else
            sat = sum_reg;
    end

    always_comb
    begin
        v_next     = v_reg;
        err_next   = err_reg;
        cur_next   = cur_reg;
        prev_next  = prev_reg;
        boost_next = boost_reg;
        sum_next   = sum_reg;
        acc_next   = acc_reg;
        drive_next = drive_reg;
        ferr_next  = ferr_reg;
        prod_next  = prod_reg;

        if (ctrl.mul != MUL_NONE)
            prod_next = $signed({1'b0, mul_a}) * mul_b;

        case (ctrl.alu)
            ALU_LOAD:
            begin
                if (v_in > FULL)
                    v_next = FULL;
                else if (v_in < NEG_FULL)
                    v_next = NEG_FULL;
                else
                    v_next = v_in;
                prev_next = cur_reg;
            end
            ALU_SELECT:
            begin
                // jump rejection: hold the last error
                if (diff_mag > VW'(cfg.jump_limit))
                    err_next = VW'(cur_reg);
                else
                    err_next = v_reg;
            end
            ALU_WRAP:
            begin
                if (err_reg > HALF)
                    err_next = err_reg - FULL;
                else if (err_reg < NEG_HALF)
                    err_next = err_reg + FULL;
                else
                    err_next = err_reg;
            end
            ALU_CLASS:
            begin
                boost_next = (err_mag > VW'(cfg.boost_threshold)) ? cfg.boost_factor
                                                                   : BOOST_ONE;
                if (err_mag < VW'(cfg.deadband))
                    cur_next = '0;
                else
                    cur_next = EW'(err_reg);
            end
            ALU_ACC_D:
            begin
                sum_next = SW'(acc_reg) + SW'(prod_reg >>> (24 - F));
            end
            ALU_ACC_P:
            begin
                sum_next = sum_reg + SW'(prod_reg >>> (16 - F));
            end
            ALU_SAT:
            begin
                acc_next   = AW'(sat);
                drive_next = OUT_W'(sat >>> F);
                ferr_next  = OUT_W'(cur_reg);
            end
            default:
            begin
                v_next = v_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_reg  <= '0;
            prev_reg <= '0;
            acc_reg  <= '0;
        end
        else
        begin
            cur_reg  <= cur_next;
            prev_reg <= prev_next;
            acc_reg  <= acc_next;
        end
    end

    always_ff @(posedge clk)
    begin
        v_reg     <= v_next;
        err_reg   <= err_next;
        boost_reg <= boost_next;
        prod_reg  <= prod_next;
        sum_reg   <= sum_next;
        drive_reg <= drive_next;
        ferr_reg  <= ferr_next;
    end

    assign drive_angle    = drive_reg;
    assign filtered_error = ferr_reg;

endmodule
